### hw/rtl/assert_macros.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock once out of reset.
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/m3i_pkg.sv
// Shared constants for the 3x3 matrix inverse.
`default_nettype none
package m3i_pkg;
    localparam int NUM_SHIFT = 24;
    localparam int Q_WIDTH = 32;
    localparam int DIV_STEPS = 32;
    localparam int NUM_LANES = 9;
    localparam logic [Q_WIDTH-1:0] Q16_ONE = 32'h0001_0000;
    localparam logic [Q_WIDTH-1:0] INV_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_WIDTH-1:0] INV_MIN = 32'h8000_0000;
endpackage
`default_nettype wire

### hw/rtl/m3i_cofactor.sv
// Two pipeline stages: minor products, then the nine cofactors.
`default_nettype none
module m3i_cofactor #(
    parameter int EW = 16,
    parameter int CW = 2 * EW + 1
) (
    input  wire logic                 clk,
    input  wire logic [1:0]           en,
    input  wire logic signed [EW-1:0] a [9],
    output logic signed [CW-1:0]      cof [9],
    output logic signed [EW-1:0]      col [3]
);
    logic signed [2*EW-1:0] p0_next [9];
    logic signed [2*EW-1:0] p1_next [9];
    logic signed [2*EW-1:0] p0_reg [9];
    logic signed [2*EW-1:0] p1_reg [9];
    logic signed [EW-1:0]   col1_reg [3];
    logic signed [CW-1:0]   cof_reg [9];
    logic signed [EW-1:0]   col2_reg [3];

    // minor products, rows and columns taken cyclically
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                int i1, i2, j1, j2;
                i1 = (i == 2) ? 0 : i + 1;
                i2 = (i == 0) ? 2 : i - 1;
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                p0_next[i*3+j] = a[i1*3+j1] * a[i2*3+j2];
                p1_next[i*3+j] = a[i1*3+j2] * a[i2*3+j1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            col1_reg <= '{a[0], a[3], a[6]};
        end
        if (en[1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                cof_reg[k] <= {p0_reg[k][2*EW-1], p0_reg[k]} - {p1_reg[k][2*EW-1], p1_reg[k]};
            end
            col2_reg <= col1_reg;
        end
    end

    assign cof = cof_reg;
    assign col = col2_reg;
endmodule
`default_nettype wire

### hw/rtl/m3i_det.sv
// Two pipeline stages: determinant products, then sum, magnitudes and signs.
`default_nettype none
module m3i_det #(
    parameter int EW = 16,
    parameter int CW = 2 * EW + 1,
    parameter int DW = 3 * EW + 3
) (
    input  wire logic                 clk,
    input  wire logic [1:0]           en,
    input  wire logic signed [CW-1:0] cof [9],
    input  wire logic signed [EW-1:0] col [3],
    output logic [CW-1:0]             mag [9],
    output logic [8:0]                neg,
    output logic [DW-1:0]             dmag,
    output logic                      sing
);
    localparam int PW = EW + CW;

    logic signed [PW-1:0] dp_reg [3];
    logic signed [CW-1:0] cof3_reg [9];
    logic signed [DW-1:0] det;
    logic [CW-1:0]        mag_reg [9];
    logic [8:0]           neg_reg;
    logic [DW-1:0]        dmag_reg;
    logic                 sing_reg;

    // expansion along the first column
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                dp_reg[r] <= col[r] * cof[r*3];
            end
            cof3_reg <= cof;
        end
    end

    assign det = {{(DW-PW){dp_reg[0][PW-1]}}, dp_reg[0]}
               + {{(DW-PW){dp_reg[1][PW-1]}}, dp_reg[1]}
               + {{(DW-PW){dp_reg[2][PW-1]}}, dp_reg[2]};

    // transpose to adjugate order, split sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    mag_reg[i*3+j] <= cof3_reg[j*3+i][CW-1] ? CW'(-cof3_reg[j*3+i])
                                                            : CW'(cof3_reg[j*3+i]);
                    neg_reg[i*3+j] <= cof3_reg[j*3+i][CW-1] ^ det[DW-1];
                end
            end
            dmag_reg <= det[DW-1] ? DW'(-det) : DW'(det);
            sing_reg <= (det == '0);
        end
    end

    assign mag  = mag_reg;
    assign neg  = neg_reg;
    assign dmag = dmag_reg;
    assign sing = sing_reg;
endmodule
`default_nettype wire

### hw/rtl/m3i_divider.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module m3i_divider #(
    parameter int CW = 33,
    parameter int DW = 51,
    parameter int RW = DW + m3i_pkg::DIV_STEPS
) (
    input  wire logic                          clk,
    input  wire logic [m3i_pkg::DIV_STEPS:0]   en,
    input  wire logic [CW-1:0]                 mag [9],
    input  wire logic [8:0]                    neg,
    input  wire logic [DW-1:0]                 dmag,
    input  wire logic                          sing,
    output logic [m3i_pkg::Q_WIDTH-1:0]        quo [9],
    output logic [8:0]                         ovf,
    output logic [8:0]                         qneg,
    output logic                               qsing
);
    localparam int NS = m3i_pkg::DIV_STEPS + 1;
    localparam int QW = m3i_pkg::Q_WIDTH;

    logic [RW-1:0]                 rem_reg [NS][9];
    logic [m3i_pkg::Q_WIDTH-1:0]   q_reg [NS][9];
    logic [8:0]                    ovf_reg [NS];
    logic [8:0]                    neg_reg [NS];
    logic [DW-1:0]                 d_reg [NS];
    logic                          sing_reg [NS];
    logic [RW-1:0]                 num [9];

    // numerator = |cofactor| * 2^24; overflow when quotient needs more than 32 bits
    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            num[l] = RW'({mag[l], {m3i_pkg::NUM_SHIFT{1'b0}}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < 9; l++)
            begin
                rem_reg[0][l] <= num[l];
                q_reg[0][l]   <= '0;
                ovf_reg[0][l] <= (num[l] >= {dmag, {m3i_pkg::DIV_STEPS{1'b0}}});
            end
            neg_reg[0]  <= neg;
            d_reg[0]    <= dmag;
            sing_reg[0] <= sing;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar k = 1; k < NS; k++)
    begin : g_step
        localparam int B = m3i_pkg::DIV_STEPS - k;
        logic [RW-1:0] sh;
        logic [8:0]    ge;

        assign sh = RW'(d_reg[k-1]) << B;

        always_comb
        begin
            for (int l = 0; l < 9; l++)
            begin
                ge[l] = (rem_reg[k-1][l] >= sh);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                for (int l = 0; l < 9; l++)
                begin
                    rem_reg[k][l] <= ge[l] ? rem_reg[k-1][l] - sh : rem_reg[k-1][l];
                    // bit B is still clear here; set it from this step's compare
                    q_reg[k][l]   <= q_reg[k-1][l] | (QW'(ge[l]) << B);
                end
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                d_reg[k]    <= d_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    assign quo   = q_reg[NS-1];
    assign ovf   = ovf_reg[NS-1];
    assign qneg  = neg_reg[NS-1];
    assign qsing = sing_reg[NS-1];
endmodule
`default_nettype wire

### hw/rtl/matrix3_inverse.sv
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
//
// Input channel: in_valid / in_ready carry one request, a 3x3 matrix of
// signed Q8.8 entries a00..a22. Output channel: out_valid / out_ready carry
// the inverse inv00..inv22 in signed Q16.16 plus singular and clipped flags.
// Each inverse entry is cofactor * 2^24 / det truncated toward zero and
// saturated; a zero determinant returns the identity with singular set.
// Stages from accept to out_valid: 2 cofactor stages, 2 determinant
// stages, 33 divider stages, 1 saturation/output stage.
// Throughput: one request per cycle; the nine divider lanes each resolve
// one quotient bit per stage so every stage holds a different request.
// Each stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles fill while the receiver stalls and
// in_ready drops only once every stage is occupied.
// Reset clears all valid bits; no request is in flight after reset.
`default_nettype none
`include "assert_macros.svh"
module matrix3_inverse #(
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ENTRY_WIDTH-1:0] a00,
    input  wire logic signed [ENTRY_WIDTH-1:0] a01,
    input  wire logic signed [ENTRY_WIDTH-1:0] a02,
    input  wire logic signed [ENTRY_WIDTH-1:0] a10,
    input  wire logic signed [ENTRY_WIDTH-1:0] a11,
    input  wire logic signed [ENTRY_WIDTH-1:0] a12,
    input  wire logic signed [ENTRY_WIDTH-1:0] a20,
    input  wire logic signed [ENTRY_WIDTH-1:0] a21,
    input  wire logic signed [ENTRY_WIDTH-1:0] a22,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 inv00,
    output logic signed [31:0]                 inv01,
    output logic signed [31:0]                 inv02,
    output logic signed [31:0]                 inv10,
    output logic signed [31:0]                 inv11,
    output logic signed [31:0]                 inv12,
    output logic signed [31:0]                 inv20,
    output logic signed [31:0]                 inv21,
    output logic signed [31:0]                 inv22,
    output logic                               singular,
    output logic                               clipped
);
    localparam int EW = ENTRY_WIDTH;
    localparam int CW = 2 * EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int RW = DW + m3i_pkg::DIV_STEPS;
    localparam int DS = m3i_pkg::DIV_STEPS + 1;
    localparam int NS = 4 + DS + 1;
    localparam int QW = m3i_pkg::Q_WIDTH;

    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        valid_next;
    logic [NS-1:0]        en;
    logic signed [EW-1:0] a [9];
    logic signed [CW-1:0] cof [9];
    logic signed [EW-1:0] col [3];
    logic [CW-1:0]        mag [9];
    logic [8:0]           neg;
    logic [DW-1:0]        dmag;
    logic                 sing;
    logic [QW-1:0]        quo [9];
    logic [8:0]           ovf;
    logic [8:0]           qneg;
    logic                 qsing;
    logic [QW-1:0]        inv_next [9];
    logic [8:0]           clip_lane;
    logic [QW-1:0]        inv_reg [9];
    logic                 sing_reg;
    logic                 clip_reg;

    assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    // stage advance: empty, or the next stage advances
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    m3i_cofactor #(.EW(EW), .CW(CW)) u_cofactor (
        .clk (clk),
        .en  (en[1:0]),
        .a   (a),
        .cof (cof),
        .col (col)
    );

    m3i_det #(.EW(EW), .CW(CW), .DW(DW)) u_det (
        .clk  (clk),
        .en   (en[3:2]),
        .cof  (cof),
        .col  (col),
        .mag  (mag),
        .neg  (neg),
        .dmag (dmag),
        .sing (sing)
    );

    m3i_divider #(.CW(CW), .DW(DW), .RW(RW)) u_divider (
        .clk   (clk),
        .en    (en[4+DS-1:4]),
        .mag   (mag),
        .neg   (neg),
        .dmag  (dmag),
        .sing  (sing),
        .quo   (quo),
        .ovf   (ovf),
        .qneg  (qneg),
        .qsing (qsing)
    );

    // sign, saturation and the singular override
    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            if (qsing)
            begin
                inv_next[l]  = (l == 0 || l == 4 || l == 8) ? m3i_pkg::Q16_ONE : '0;
                clip_lane[l] = 1'b0;
            end
            else if (qneg[l])
            begin
                clip_lane[l] = ovf[l] || (quo[l] > m3i_pkg::INV_MIN);
                inv_next[l]  = clip_lane[l] ? m3i_pkg::INV_MIN : QW'(-quo[l]);
            end
            else
            begin
                clip_lane[l] = ovf[l] || (quo[l] > m3i_pkg::INV_MAX);
                inv_next[l]  = clip_lane[l] ? m3i_pkg::INV_MAX : quo[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            inv_reg  <= inv_next;
            sing_reg <= qsing;
            clip_reg <= |clip_lane;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];
    assign inv00     = inv_reg[0];
    assign inv01     = inv_reg[1];
    assign inv02     = inv_reg[2];
    assign inv10     = inv_reg[3];
    assign inv11     = inv_reg[4];
    assign inv12     = inv_reg[5];
    assign inv20     = inv_reg[6];
    assign inv21     = inv_reg[7];
    assign inv22     = inv_reg[8];
    assign singular  = sing_reg;
    assign clipped   = clip_reg;

    `M3I_ASSERT_NOW(a_full_stall, !in_ready,
        out_valid && !out_ready && (&valid_reg),
        "in_ready low without a full stalled pipeline")
    `M3I_ASSERT_NOW(a_sing_noclip, out_valid && singular, !clipped,
        "singular result flagged clipped")
    `M3I_ASSERT_NOW(a_sing_ident, out_valid && singular,
        inv00 == m3i_pkg::Q16_ONE && inv01 == 0,
        "singular result not identity")
    `M3I_ASSERT_NEXT(a_fill, in_valid && in_ready, valid_reg[0],
        "accepted request not captured")
endmodule
`default_nettype wire

### tb/matrix3_inverse_tb.sv
// Testbench for matrix3_inverse: adjugate-based inverse checked against an in-bench predictor.
`timescale 1ns / 100ps
`default_nettype none
module matrix3_inverse_tb;
    localparam int EW = 16;

    typedef struct packed {
        logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    } matrix_t;

    typedef struct packed {
        logic [31:0] v00, v01, v02, v10, v11, v12, v20, v21, v22;
        logic        sing;
        logic        clip;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [EW-1:0] a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0;
    logic signed [EW-1:0] a12 = '0, a20 = '0, a21 = '0, a22 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic singular, clipped;

    matrix3_inverse #(.ENTRY_WIDTH(EW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
        .a20(a20), .a21(a21), .a22(a22),
        .out_valid(out_valid), .out_ready(out_ready),
        .inv00(inv00), .inv01(inv01), .inv02(inv02), .inv10(inv10), .inv11(inv11),
        .inv12(inv12), .inv20(inv20), .inv21(inv21), .inv22(inv22),
        .singular(singular), .clipped(clipped)
    );

    always #5 clk = ~clk;

    matrix_t  pending_reqs[$];
    inverse_t expected_inverses[$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       recv_hold = 1'b0;

    // One inverse entry: cofactor * 2^24 / det, truncated toward zero, saturated.
    function automatic logic [31:0] divide_entry(input logic signed [63:0] cof,
                                                 input logic signed [127:0] det,
                                                 ref bit sat);
        logic [127:0] num_mag, det_mag, quo;
        bit           neg;
        num_mag = (cof < 0) ? 128'(-cof) : 128'(cof);
        num_mag = num_mag << m3i_pkg::NUM_SHIFT;
        det_mag = (det < 0) ? -det : det;
        neg = (cof < 0) != (det < 0);
        quo = num_mag / det_mag;
        if (neg)
        begin
            if (quo > 128'h8000_0000)
            begin
                sat = 1'b1;
                return m3i_pkg::INV_MIN;
            end
            return 32'(-quo);
        end
        if (quo > 128'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return m3i_pkg::INV_MAX;
        end
        return quo[31:0];
    endfunction

    // Full inverse of one matrix by adjugate over determinant.
    function automatic inverse_t invert_matrix(input matrix_t m);
        logic signed [63:0]  a[3][3];
        logic signed [63:0]  c[3][3];
        logic signed [127:0] det;
        logic [31:0]         r[3][3];
        bit                  sat;
        inverse_t            res;
        sat = 1'b0;
        a[0][0] = m.e00; a[0][1] = m.e01; a[0][2] = m.e02;
        a[1][0] = m.e10; a[1][1] = m.e11; a[1][2] = m.e12;
        a[2][0] = m.e20; a[2][1] = m.e21; a[2][2] = m.e22;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                        - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        det = 128'(a[0][0]) * 128'(c[0][0]) + 128'(a[1][0]) * 128'(c[1][0])
            + 128'(a[2][0]) * 128'(c[2][0]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (det == 0) r[i][j] = (i == j) ? m3i_pkg::Q16_ONE : '0;
                else r[i][j] = divide_entry(c[j][i], det, sat);
        res = '{r[0][0], r[0][1], r[0][2], r[1][0], r[1][1], r[1][2],
                r[2][0], r[2][1], r[2][2], det == 0, sat};
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH %s at %0t", what, $time);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h want %h", what, got, want));
    endtask

    // Driver: presents queued requests, keeps valid and payload until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    matrix_t m;
                    m = pending_reqs.pop_front();
                    expected_inverses.push_back(invert_matrix(m));
                    {a00, a01, a02, a10, a11, a12, a20, a21, a22} <= m;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted response against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    report_mismatch("unexpected response");
                end
                else
                begin
                    inverse_t e;
                    e = expected_inverses.pop_front();
                    check_field("inv00", inv00, e.v00);
                    check_field("inv01", inv01, e.v01);
                    check_field("inv02", inv02, e.v02);
                    check_field("inv10", inv10, e.v10);
                    check_field("inv11", inv11, e.v11);
                    check_field("inv12", inv12, e.v12);
                    check_field("inv20", inv20, e.v20);
                    check_field("inv21", inv21, e.v21);
                    check_field("inv22", inv22, e.v22);
                    check_field("singular", 32'(singular), 32'(e.sing));
                    check_field("clipped", 32'(clipped), 32'(e.clip));
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off to back the pipeline up into in_ready.
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        recv_hold <= 1'b1;
        repeat (120) @(posedge clk);
        recv_hold <= 1'b0;
    end

    function automatic logic signed [EW-1:0] rand_entry();
        case ($urandom_range(5, 0))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return EW'($signed($urandom_range(8, 0)) - 4);
            3: return EW'($signed($urandom_range(1024, 0)) - 512);
            default: return EW'($urandom);
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // Some singular ones: duplicate a row.
        if ($urandom_range(9, 0) == 0) {m.e20, m.e21, m.e22} = {m.e00, m.e01, m.e02};
        return m;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_inverses.size() > 0 ||
               in_valid) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: identity, scaled identity, zero, extremes, tiny det, negatives.
        pending_reqs.push_back({16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0,
                                16'sd0, 16'sd0, 16'sd256});
        pending_reqs.push_back({16'sd512, 16'sd0, 16'sd0, 16'sd0, -16'sd512, 16'sd0,
                                16'sd0, 16'sd0, 16'sd128});
        pending_reqs.push_back('0);
        pending_reqs.push_back({9{16'sh7FFF}});
        pending_reqs.push_back({9{16'sh8000}});
        pending_reqs.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                                16'sd0, 16'sd0, 16'sd1});
        pending_reqs.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0,
                                16'sd0, 16'sd0, 16'sd1});
        pending_reqs.push_back({16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
                                16'sd0, 16'sd0, 16'sh8000});
        pending_reqs.push_back({16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0,
                                16'sd0, 16'sd0, 16'sh7FFF});
        pending_reqs.push_back({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
        pending_reqs.push_back({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, 16'sd256});
        pending_reqs.push_back({-16'sd1, 16'sh7FFF, 16'sd3, 16'sd2, -16'sd7, 16'sh8000,
                                16'sd5, 16'sd1, -16'sd1});
        drain();
        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 54 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 31 : 0;
            for (int k = 0; k < 310; k++) pending_reqs.push_back(rand_matrix());
            // Sender pauses here until all responses are back.
            drain();
        end
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("matrix3_inverse verification clean");
        else
            $display("matrix3_inverse verification failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #2000000;
        $display("matrix3_inverse verification failed");
        $finish;
    end
endmodule
`default_nettype wire
